### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the immediate instruction unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds whenever the antecedent holds.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

// Check that a condition is never seen.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

`endif

### design/riu_pkg.sv
// ----------------------------------------------------------------------------
// riu_pkg
// Types, opcodes and helper functions for the immediate instruction unit.
// ----------------------------------------------------------------------------
package riu_pkg;

    localparam int DEF_MEM_ADDR_BITS = 12;

    // Immediate-format opcodes
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0A;
    localparam logic [5:0] OP_SLTIU = 6'h0B;
    localparam logic [5:0] OP_ANDI  = 6'h0C;
    localparam logic [5:0] OP_ORI   = 6'h0D;
    localparam logic [5:0] OP_XORI  = 6'h0E;
    localparam logic [5:0] OP_LUI   = 6'h0F;
    localparam logic [5:0] OP_LB    = 6'h20;
    localparam logic [5:0] OP_LH    = 6'h21;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_LBU   = 6'h24;
    localparam logic [5:0] OP_LHU   = 6'h25;
    localparam logic [5:0] OP_SB    = 6'h28;
    localparam logic [5:0] OP_SH    = 6'h29;
    localparam logic [5:0] OP_SW    = 6'h2B;

    // Load extraction kinds
    typedef logic [2:0] t_ld_kind;
    localparam t_ld_kind LD_B  = 3'd0;
    localparam t_ld_kind LD_BU = 3'd1;
    localparam t_ld_kind LD_H  = 3'd2;
    localparam t_ld_kind LD_HU = 3'd3;
    localparam t_ld_kind LD_W  = 3'd4;

    // Memory access sizes
    typedef logic [1:0] t_mem_size;
    localparam t_mem_size SZ_BYTE = 2'd0;
    localparam t_mem_size SZ_HALF = 2'd1;
    localparam t_mem_size SZ_WORD = 2'd2;

    // Data memory request
    typedef struct packed {
        logic      rd;
        logic      wr;
        t_mem_size size;
    } t_mem_ctl;

    // Execute result of one instruction
    typedef struct packed {
        logic [31:0] npc;
        logic [31:0] val;
        logic [31:0] ea;
        logic [31:0] st_data;
        logic        wreg;
        logic        wmem;
        logic        ld;
        t_ld_kind    ld_kind;
        t_mem_size   size;
        logic        bad;
    } t_exec;

    // Shape a little-endian load word into the register value
    function automatic logic [31:0] load_ext(input logic [31:0] raw, input t_ld_kind kind);
        logic [31:0] v;
        begin
            unique case (kind)
                LD_B:    v = {{24{raw[7]}}, raw[7:0]};
                LD_BU:   v = {24'h000000, raw[7:0]};
                LD_H:    v = {{16{raw[15]}}, raw[15:0]};
                LD_HU:   v = {16'h0000, raw[15:0]};
                LD_W:    v = raw;
                default: v = raw;
            endcase
            return v;
        end
    endfunction

endpackage

### design/risc_immediate_instruction_unit_top.sv
// Executes one immediate-format instruction per beat against a 32-entry
// register file and a byte-addressed little-endian data memory of
// 2**MEM_ADDR_BITS bytes. One instruction is accepted every cycle that
// o_ready is high; it passes register read, execute and memory access,
// then load shaping and register write into the output register. The
// register file is read at acceptance and forwarded from the stage ahead,
// and stores and loads both touch memory in the execute stage, so back-to-back
// dependent instructions need no stall. After reset the data memory clears
// itself, one 4-byte row per cycle, over all 2**(MEM_ADDR_BITS-2) rows (1024
// at the default size); o_ready stays low during that pass.
// ----------------------------------------------------------------------------
// risc_immediate_instruction_unit_top
// Three-stage immediate instruction execute unit with valid/ready channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module risc_immediate_instruction_unit_top
    import riu_pkg::*;
#(
    parameter int MEM_ADDR_BITS = DEF_MEM_ADDR_BITS
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_instruction_word,
    input  logic [31:0] i_current_pc,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_next_pc,
    output logic        o_writes_register,
    output logic [4:0]  o_dest_register,
    output logic [31:0] o_register_value,
    output logic        o_writes_memory,
    output logic        o_unsupported_opcode
);

    logic        adv;
    logic        acc;
    logic        mem_busy;

    // Execute stage
    logic        r_a_valid;
    logic [31:0] r_a_iw;
    logic [31:0] r_a_pc;
    logic [31:0] rf_a;
    logic [31:0] rf_b;
    logic [31:0] op_a;
    logic [31:0] op_b;
    t_exec       ex;
    t_mem_ctl    mem_ctl;
    logic [31:0] mem_rdata;

    // Writeback stage
    logic        r_b_valid;
    logic [31:0] r_b_npc;
    logic [31:0] r_b_val;
    logic        r_b_wreg;
    logic [4:0]  r_b_rt;
    logic        r_b_wmem;
    logic        r_b_bad;
    logic        r_b_ld;
    t_ld_kind    r_b_ld_kind;
    logic [31:0] b_val;
    logic        rf_we;

    // Output register
    logic        r_c_valid;
    logic [31:0] r_c_npc;
    logic        r_c_wreg;
    logic [4:0]  r_c_rt;
    logic [31:0] r_c_val;
    logic        r_c_wmem;
    logic        r_c_bad;

    // Move the whole pipe when the output register can take a beat
    assign adv     = !r_c_valid || i_ready;
    assign o_ready = adv && !mem_busy;
    assign acc     = i_valid && o_ready;

    riu_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_re      (acc),
        .i_raddr_a (i_instruction_word[25:21]),
        .i_raddr_b (i_instruction_word[20:16]),
        .i_we      (rf_we),
        .i_waddr   (r_b_rt),
        .i_wdata   (b_val),
        .o_rdata_a (rf_a),
        .o_rdata_b (rf_b)
    );

    // Forward the result of the instruction one stage ahead
    always_comb begin
        op_a = rf_a;
        op_b = rf_b;
        if (r_b_valid && r_b_wreg && (r_b_rt == r_a_iw[25:21])) begin
            op_a = b_val;
        end
        if (r_b_valid && r_b_wreg && (r_b_rt == r_a_iw[20:16])) begin
            op_b = b_val;
        end
    end

    riu_alu u_alu (
        .i_iw   (r_a_iw),
        .i_pc   (r_a_pc),
        .i_a    (op_a),
        .i_b    (op_b),
        .o_exec (ex)
    );

    // Issue the memory access as the instruction leaves execute
    always_comb begin
        mem_ctl.rd   = r_a_valid && adv && ex.ld;
        mem_ctl.wr   = r_a_valid && adv && ex.wmem;
        mem_ctl.size = ex.size;
    end

    riu_dmem #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (ex.ea[MEM_ADDR_BITS-1:0]),
        .i_ctl   (mem_ctl),
        .i_wdata (ex.st_data),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    // Shape load data and write the register file
    assign b_val = r_b_ld ? load_ext(mem_rdata, r_b_ld_kind) : r_b_val;
    assign rf_we = adv && r_b_valid && r_b_wreg;

    // Advance valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= acc;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Capture the incoming beat
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_iw <= i_instruction_word;
            r_a_pc <= i_current_pc;
        end
    end

    // Advance payload through writeback and output
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_npc     <= ex.npc;
            r_b_val     <= ex.val;
            r_b_wreg    <= ex.wreg;
            r_b_rt      <= r_a_iw[20:16];
            r_b_wmem    <= ex.wmem;
            r_b_bad     <= ex.bad;
            r_b_ld      <= ex.ld;
            r_b_ld_kind <= ex.ld_kind;
            r_c_npc     <= r_b_npc;
            r_c_wreg    <= r_b_wreg;
            r_c_rt      <= r_b_wreg ? r_b_rt : 5'd0;
            r_c_val     <= r_b_wreg ? b_val : 32'h0;
            r_c_wmem    <= r_b_wmem;
            r_c_bad     <= r_b_bad;
        end
    end

    assign o_valid              = r_c_valid;
    assign o_next_pc            = r_c_npc;
    assign o_writes_register    = r_c_wreg;
    assign o_dest_register      = r_c_rt;
    assign o_register_value     = r_c_val;
    assign o_writes_memory      = r_c_wmem;
    assign o_unsupported_opcode = r_c_bad;

    `ASSERT_IMPL(a_dest_nonzero, i_clk, i_rst_n, o_valid && o_writes_register,
                 o_dest_register != 5'd0)
    `ASSERT_NEVER(a_reg_mem_excl, i_clk, i_rst_n, o_valid && o_writes_register && o_writes_memory)
    `ASSERT_IMPL(a_bad_no_effect, i_clk, i_rst_n, o_valid && o_unsupported_opcode,
                 !o_writes_register && !o_writes_memory)
    `ASSERT_NEVER(a_no_accept_in_clear, i_clk, i_rst_n,
                  mem_busy && (r_a_valid || r_b_valid || r_c_valid))

endmodule

### design/riu_regfile.sv
// ----------------------------------------------------------------------------
// riu_regfile
// 32 x 32 register file, two registered read ports, one write port, with
// per-entry valid bits so that reset reads as zero and write-first bypass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module riu_regfile
    import riu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_re,
    input  logic [4:0]  i_raddr_a,
    input  logic [4:0]  i_raddr_b,
    input  logic        i_we,
    input  logic [4:0]  i_waddr,
    input  logic [31:0] i_wdata,
    output logic [31:0] o_rdata_a,
    output logic [31:0] o_rdata_b
);

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_data_a;
    logic [31:0] r_data_b;
    logic        r_ok_a;
    logic        r_ok_b;
    logic        r_hit_a;
    logic        r_hit_b;
    logic [31:0] r_wd;

    // Track written entries; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // Write the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read both ports, capture a same-edge write for bypass
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_data_a <= r_mem[i_raddr_a];
            r_data_b <= r_mem[i_raddr_b];
            r_ok_a   <= r_vld[i_raddr_a];
            r_ok_b   <= r_vld[i_raddr_b];
            r_hit_a  <= i_we && (i_waddr == i_raddr_a);
            r_hit_b  <= i_we && (i_waddr == i_raddr_b);
            r_wd     <= i_wdata;
        end
    end

    assign o_rdata_a = r_hit_a ? r_wd : (r_ok_a ? r_data_a : 32'h0);
    assign o_rdata_b = r_hit_b ? r_wd : (r_ok_b ? r_data_b : 32'h0);

    `ASSERT_NEVER(a_no_zero_write, i_clk, i_rst_n, i_we && (i_waddr == 5'd0))

endmodule

### design/riu_dmem.sv
// ----------------------------------------------------------------------------
// riu_dmem
// Byte-addressed data memory built from four byte banks, so that one
// unaligned word access touches each bank once. Clears itself after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module riu_dmem
    import riu_pkg::*;
#(
    parameter int MEM_ADDR_BITS = DEF_MEM_ADDR_BITS
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [MEM_ADDR_BITS-1:0] i_addr,
    input  t_mem_ctl                 i_ctl,
    input  logic [31:0]              i_wdata,
    output logic [31:0]              o_rdata,
    output logic                     o_busy
);

    localparam int ROW_BITS = MEM_ADDR_BITS - 2;
    localparam int ROWS     = 1 << ROW_BITS;

    logic                r_clearing;
    logic [ROW_BITS-1:0] r_clr_row;
    logic [1:0]          r_lo;
    logic [7:0]          r_q [4];
    logic [ROW_BITS-1:0] base;
    logic [1:0]          lo;

    assign base = i_addr[MEM_ADDR_BITS-1:2];
    assign lo   = i_addr[1:0];

    // Sweep every row once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clearing) begin
            r_clr_row <= r_clr_row + {{(ROW_BITS-1){1'b0}}, 1'b1};
            if (r_clr_row == {ROW_BITS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Hold the byte rotation for the read in flight
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_lo <= lo;
        end
    end

    for (genvar j = 0; j < 4; j++) begin : g_bank
        logic [7:0]          r_mem [ROWS];
        logic [1:0]          k;
        logic [ROW_BITS-1:0] row;
        logic                fit;
        logic                wr_en;
        logic [ROW_BITS-1:0] wr_row;
        logic [7:0]          wr_dat;

        // Pick which byte of the access lands in this bank, and its row
        always_comb begin
            k   = 2'(j) - lo;
            row = base + {{(ROW_BITS-1){1'b0}}, (2'(j) < lo)};
            unique case (i_ctl.size)
                SZ_BYTE: fit = (k == 2'd0);
                SZ_HALF: fit = !k[1];
                SZ_WORD: fit = 1'b1;
                default: fit = 1'b0;
            endcase
            wr_en  = r_clearing || (i_ctl.wr && fit);
            wr_row = r_clearing ? r_clr_row : row;
            wr_dat = r_clearing ? 8'h00 : i_wdata[{k, 3'b000} +: 8];
        end

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[wr_row] <= wr_dat;
            end
            if (i_ctl.rd) begin
                r_q[j] <= r_mem[row];
            end
        end
    end

    // Rotate bank outputs back into address order
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            o_rdata[8*b +: 8] = r_q[2'(r_lo + 2'(b))];
        end
    end

    assign o_busy = r_clearing;

    `ASSERT_NEVER(a_no_store_in_clear, i_clk, i_rst_n, r_clearing && i_ctl.wr)

endmodule

### design/riu_alu.sv
// ----------------------------------------------------------------------------
// riu_alu
// Decode and execute of one immediate-format instruction: arithmetic,
// logic, compare, branch target and effective address.
// ----------------------------------------------------------------------------
module riu_alu
    import riu_pkg::*;
(
    input  logic [31:0] i_iw,
    input  logic [31:0] i_pc,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output t_exec       o_exec
);

    logic [5:0]  op;
    logic [4:0]  rt;
    logic [31:0] zimm;
    logic [31:0] simm;
    logic [31:0] pc4;
    logic [31:0] target;

    assign op     = i_iw[31:26];
    assign rt     = i_iw[20:16];
    assign zimm   = {16'h0000, i_iw[15:0]};
    assign simm   = {{16{i_iw[15]}}, i_iw[15:0]};
    assign pc4    = i_pc + 32'd4;
    assign target = pc4 + {simm[29:0], 2'b00};

    // Decode and compute
    always_comb begin
        o_exec         = '0;
        o_exec.npc     = pc4;
        o_exec.ea      = i_a + simm;
        o_exec.st_data = i_b;
        o_exec.ld_kind = LD_W;
        o_exec.size    = SZ_WORD;
        unique case (op)
            OP_BEQ:   if (i_a == i_b) o_exec.npc = target;
            OP_BNE:   if (i_a != i_b) o_exec.npc = target;
            OP_ADDI, OP_ADDIU: begin
                o_exec.val  = i_a + simm;
                o_exec.wreg = 1'b1;
            end
            OP_SLTI: begin
                o_exec.val  = {31'd0, ($signed(i_a) < $signed(simm))};
                o_exec.wreg = 1'b1;
            end
            OP_SLTIU: begin
                o_exec.val  = {31'd0, (i_a < simm)};
                o_exec.wreg = 1'b1;
            end
            OP_ANDI: begin
                o_exec.val  = i_a & zimm;
                o_exec.wreg = 1'b1;
            end
            OP_ORI: begin
                o_exec.val  = i_a | zimm;
                o_exec.wreg = 1'b1;
            end
            OP_XORI: begin
                o_exec.val  = i_a ^ zimm;
                o_exec.wreg = 1'b1;
            end
            OP_LUI: begin
                o_exec.val  = {i_iw[15:0], 16'h0000};
                o_exec.wreg = 1'b1;
            end
            OP_LB: begin
                o_exec.ld = 1'b1; o_exec.ld_kind = LD_B; o_exec.wreg = 1'b1;
            end
            OP_LBU: begin
                o_exec.ld = 1'b1; o_exec.ld_kind = LD_BU; o_exec.wreg = 1'b1;
            end
            OP_LH: begin
                o_exec.ld = 1'b1; o_exec.ld_kind = LD_H; o_exec.wreg = 1'b1;
            end
            OP_LHU: begin
                o_exec.ld = 1'b1; o_exec.ld_kind = LD_HU; o_exec.wreg = 1'b1;
            end
            OP_LW: begin
                o_exec.ld = 1'b1; o_exec.ld_kind = LD_W; o_exec.wreg = 1'b1;
            end
            OP_SB: begin
                o_exec.wmem = 1'b1; o_exec.size = SZ_BYTE;
            end
            OP_SH: begin
                o_exec.wmem = 1'b1; o_exec.size = SZ_HALF;
            end
            OP_SW: begin
                o_exec.wmem = 1'b1; o_exec.size = SZ_WORD;
            end
            default: o_exec.bad = 1'b1;
        endcase
        // Register zero is never written
        if (rt == 5'd0) begin
            o_exec.wreg = 1'b0;
        end
    end

endmodule
